@@ design/acr_pkg.sv @@
package acr_pkg;

  // Default coordinate width; inputs are sign-extended from this many bits.
  localparam int COORD_WIDTH_DEF = 32;

  // Fixed widths of the stream fields and the configuration registers.
  localparam int FIELD_W = 32;
  localparam int OUT_W   = 32;
  localparam int CFG_W   = 16;
  localparam int N_IN    = 8;
  localparam int N_OUT   = 9;
  localparam int USER_W  = 2;

  // Fixed-point formats: unit vectors in Q2.30, gradient divisor d * 2^14.
  localparam int UNIT_FRAC  = 30;
  localparam int UNIT_W     = 32;
  localparam int PROD_W     = 64;
  localparam int TERM_W     = 33;
  localparam int GRAD_SHIFT = 14;

  // Bit positions inside the result tuser.
  localparam int USER_COS   = 0;
  localparam int USER_DEGEN = 1;

  localparam logic signed [CFG_W-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [CFG_W-1:0] SIN_RESET = 16'sd0;

  typedef enum logic [0:0] {
    CFG_COS = 1'b0,
    CFG_SIN = 1'b1
  } cfg_reg_t;

endpackage

@@ design/acr_isqrt.sv @@
module acr_isqrt #(
  parameter int LANES = 2,
  parameter int SW    = 33,
  parameter int SBW   = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [2*SW-1:0]   rad_i [LANES],
  input  logic [SBW-1:0]    side_i,
  output logic              vld_o,
  output logic [SW-1:0]     root_o [LANES],
  output logic [SBW-1:0]    side_o
);

  localparam int RW = SW + 3;
  localparam int NW = 2 * SW;

  // One root bit is settled in each stage.
  logic [RW-1:0]  rem_r  [SW][LANES];
  logic [RW-1:0]  rem_nxt[SW][LANES];
  logic [SW-1:0]  root_r  [SW][LANES];
  logic [SW-1:0]  root_nxt[SW][LANES];
  logic [NW-1:0]  rad_r  [SW][LANES];
  logic [NW-1:0]  rad_nxt[SW][LANES];
  logic [SBW-1:0] side_r  [SW];
  logic [SBW-1:0] side_nxt[SW];
  logic [SW-1:0]  vld_r;

  always_comb begin
    logic [RW-1:0] r_in;
    logic [RW-1:0] r2;
    logic [RW-1:0] trial;
    logic [SW-1:0] q_in;
    logic [NW-1:0] w_in;
    for (int s = 0; s < SW; s++) begin
      side_nxt[s] = (s == 0) ? side_i : side_r[(s == 0) ? 0 : s - 1];
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          r_in = '0;
          q_in = '0;
          w_in = rad_i[l];
        end else begin
          r_in = rem_r[s-1][l];
          q_in = root_r[s-1][l];
          w_in = rad_r[s-1][l];
        end
        r2    = {r_in[RW-3:0], w_in[NW-1 -: 2]};
        trial = {1'b0, q_in, 2'b01};
        if (r2 >= trial) begin
          rem_nxt[s][l]  = r2 - trial;
          root_nxt[s][l] = {q_in[SW-2:0], 1'b1};
        end else begin
          rem_nxt[s][l]  = r2;
          root_nxt[s][l] = {q_in[SW-2:0], 1'b0};
        end
        rad_nxt[s][l] = {w_in[NW-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
      side_r <= side_nxt;
    end
  end

  assign vld_o  = vld_r[SW-1];
  assign root_o = root_r[SW-1];
  assign side_o = side_r[SW-1];

endmodule

@@ design/acr_div.sv @@
module acr_div #(
  parameter int LANES = 4,
  parameter int DB    = 33,
  parameter int QB    = 32,
  parameter int SBW   = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [DB-1:0]   rem_i [LANES],
  input  logic [QB-1:0]   num_i [LANES],
  input  logic [DB-1:0]   den_i [LANES],
  input  logic [SBW-1:0]  side_i,
  output logic            vld_o,
  output logic [QB-1:0]   quo_o [LANES],
  output logic [SBW-1:0]  side_o
);

  // Restoring division, one quotient bit per stage. The starting partial
  // remainder must already be below the divisor.
  logic [DB-1:0]  rem_r  [QB][LANES];
  logic [DB-1:0]  rem_nxt[QB][LANES];
  logic [QB-1:0]  wrd_r  [QB][LANES];
  logic [QB-1:0]  wrd_nxt[QB][LANES];
  logic [DB-1:0]  den_r  [QB][LANES];
  logic [DB-1:0]  den_nxt[QB][LANES];
  logic [SBW-1:0] side_r  [QB];
  logic [SBW-1:0] side_nxt[QB];
  logic [QB-1:0]  vld_r;

  always_comb begin
    logic [DB-1:0] r_in;
    logic [DB-1:0] d_in;
    logic [QB-1:0] w_in;
    logic [DB:0]   r2;
    logic          qbit;
    for (int s = 0; s < QB; s++) begin
      side_nxt[s] = (s == 0) ? side_i : side_r[(s == 0) ? 0 : s - 1];
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          r_in = rem_i[l];
          d_in = den_i[l];
          w_in = num_i[l];
        end else begin
          r_in = rem_r[s-1][l];
          d_in = den_r[s-1][l];
          w_in = wrd_r[s-1][l];
        end
        r2   = {r_in, w_in[QB-1]};
        qbit = (r2 >= {1'b0, d_in});
        rem_nxt[s][l] = qbit ? DB'(r2 - {1'b0, d_in}) : r2[DB-1:0];
        wrd_nxt[s][l] = {w_in[QB-2:0], qbit};
        den_nxt[s][l] = d_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QB-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      wrd_r  <= wrd_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign vld_o  = vld_r[QB-1];
  assign quo_o  = wrd_r[QB-1];
  assign side_o = side_r[QB-1];

endmodule

@@ design/angle_constraint_residual_gradient.sv @@
// One request per cycle while no result waits at the output; the root stages, the unit-vector divider
// and the gradient divider are fully pipelined, one bit per stage.
// The whole pipeline holds while a result waits at the output unaccepted.
// Reset (synchronous, rst_n low) clears every valid bit and loads cos = 1.0, sin = 0.
module angle_constraint_residual_gradient #(
  parameter int COORD_WIDTH = acr_pkg::COORD_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // Fields from bit 0 up: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y (32 bits each).
  input  logic [acr_pkg::N_IN*acr_pkg::FIELD_W-1:0]   in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // Fields from bit 0 up: residual, grad_first_start_x, grad_first_end_x,
  // grad_second_start_x, grad_second_end_x, grad_first_start_y,
  // grad_first_end_y, grad_second_start_y, grad_second_end_y (32 bits each).
  output logic [acr_pkg::N_OUT*acr_pkg::OUT_W-1:0]    out_tdata,
  // Fields from bit 0 up: used_cosine, degenerate.
  output logic [acr_pkg::USER_W-1:0]                  out_tuser,
  input  logic                                        cfg_we,
  input  logic [0:0]                                  cfg_index,
  input  logic [acr_pkg::CFG_W-1:0]                   cfg_wdata
);
  import acr_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;          // segment difference
  localparam int SW   = CW + 1;          // segment length (floor of the root)
  localparam int RADW = 2 * SW;          // sum of squares fed to the root
  localparam int NW   = SW + TERM_W;     // length times a term
  localparam int HW   = NW - GRAD_SHIFT - OUT_W;
  localparam int EXTW = SW - HW;
  localparam int QU   = UNIT_FRAC + 1;   // unit-component quotient bits

  // Configuration registers; the user must write them only while the pipeline is empty (not enforced here).
  logic signed [CFG_W-1:0] cos_r;
  logic signed [CFG_W-1:0] sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= COS_RESET;
      sin_r <= SIN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_COS: cos_r <= cfg_wdata;
        CFG_SIN: sin_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Every stage moves together whenever the output slot is free or taken.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------
  // Stage A: sign-extend the coordinates (zero-extend when COORD_WIDTH exceeds 32) and form the direction vectors.
  // Order of vectors: x0, y0, x1, y1.
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] crd [N_IN];

  for (genvar gi = 0; gi < N_IN; gi++) begin : g_crd
    if (CW <= FIELD_W) begin : g_narrow
      assign crd[gi] = in_tdata[gi*FIELD_W +: CW];
    end else begin : g_wide
      assign crd[gi] = {{(CW-FIELD_W){1'b0}}, in_tdata[gi*FIELD_W +: FIELD_W]};
    end
  end

  logic                 a_vld_r;
  logic signed [DW-1:0] a_v_r   [4];
  logic signed [DW-1:0] a_v_nxt [4];

  always_comb begin
    a_v_nxt[0] = DW'(crd[2]) - DW'(crd[0]);
    a_v_nxt[1] = DW'(crd[3]) - DW'(crd[1]);
    a_v_nxt[2] = DW'(crd[6]) - DW'(crd[4]);
    a_v_nxt[3] = DW'(crd[7]) - DW'(crd[5]);
  end

  // ---------------------------------------------------------------------
  // Stage B: magnitudes and their squares.
  // ---------------------------------------------------------------------
  logic              b_vld_r;
  logic [3:0]        b_sgn_r,  b_sgn_nxt;
  logic [DW-1:0]     b_mag_r   [4];
  logic [DW-1:0]     b_mag_nxt [4];
  logic [2*DW-1:0]   b_sq_r    [4];
  logic [2*DW-1:0]   b_sq_nxt  [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      b_sgn_nxt[j] = a_v_r[j][DW-1];
      b_mag_nxt[j] = a_v_r[j][DW-1] ? DW'(-a_v_r[j]) : DW'(a_v_r[j]);
      b_sq_nxt[j]  = b_mag_nxt[j] * b_mag_nxt[j];
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: squared lengths of both segments.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [3:0]         sgn;
    logic [3:0][DW-1:0] mag;
  } sq_side_t;

  logic            c_vld_r;
  logic [RADW-1:0] c_rad_r   [2];
  logic [RADW-1:0] c_rad_nxt [2];
  sq_side_t        c_side_r, c_side_nxt;

  always_comb begin
    c_rad_nxt[0] = RADW'(b_sq_r[0]) + RADW'(b_sq_r[1]);
    c_rad_nxt[1] = RADW'(b_sq_r[2]) + RADW'(b_sq_r[3]);
    c_side_nxt.sgn = b_sgn_r;
    for (int j = 0; j < 4; j++) begin
      c_side_nxt.mag[j] = b_mag_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_v_r    <= a_v_nxt;
      b_sgn_r  <= b_sgn_nxt;
      b_mag_r  <= b_mag_nxt;
      b_sq_r   <= b_sq_nxt;
      c_rad_r  <= c_rad_nxt;
      c_side_r <= c_side_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Segment lengths: pipelined integer square root, one bit per stage.
  // ---------------------------------------------------------------------
  logic          sq_vld;
  logic [SW-1:0] sq_len [2];
  sq_side_t      sq_side;

  acr_isqrt #(
    .LANES (2),
    .SW    (SW),
    .SBW   ($bits(sq_side_t))
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (c_vld_r),
    .rad_i  (c_rad_r),
    .side_i (c_side_r),
    .vld_o  (sq_vld),
    .root_o (sq_len),
    .side_o (sq_side)
  );

  // ---------------------------------------------------------------------
  // Unit vectors: |v| * 2^30 / d, truncated. Because |v| never exceeds d,
  // starting with |v| / 2 as the partial remainder keeps the quotient at 31 bits.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [3:0]    sgn;
    logic [SW-1:0] d0;
    logic [SW-1:0] d1;
  } u_side_t;

  logic [SW-1:0] u_rem [4];
  logic [QU-1:0] u_num [4];
  logic [SW-1:0] u_den [4];
  u_side_t       u_side_in, u_side_out;
  logic          u_vld;
  logic [QU-1:0] u_quo [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      u_rem[j] = SW'(sq_side.mag[j] >> 1);
      u_num[j] = {sq_side.mag[j][0], {UNIT_FRAC{1'b0}}};
      u_den[j] = (j < 2) ? sq_len[0] : sq_len[1];
    end
    u_side_in.sgn = sq_side.sgn;
    u_side_in.d0  = sq_len[0];
    u_side_in.d1  = sq_len[1];
  end

  acr_div #(
    .LANES (4),
    .DB    (SW),
    .QB    (QU),
    .SBW   ($bits(u_side_t))
  ) u_unit_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .rem_i  (u_rem),
    .num_i  (u_num),
    .den_i  (u_den),
    .side_i (u_side_in),
    .vld_o  (u_vld),
    .quo_o  (u_quo),
    .side_o (u_side_out)
  );

  // ---------------------------------------------------------------------
  // Stage E: signed unit components ux0, uy0, ux1, uy1.
  // Stage F: the four products for dot and cross.
  // Stage G: dot and cross in Q2.30, rounded toward minus infinity.
  // Stage H: pick the equation and its product term.
  // ---------------------------------------------------------------------
  logic                     e_vld_r, f_vld_r, g_vld_r, h_vld_r;
  logic signed [UNIT_W-1:0] e_u_r [4];
  logic signed [UNIT_W-1:0] e_u_nxt [4];
  logic [SW-1:0]            e_d0_r, e_d1_r;
  logic signed [UNIT_W-1:0] f_u_r [4];
  logic signed [PROD_W-1:0] f_p_r [4];
  logic signed [PROD_W-1:0] f_p_nxt [4];
  logic [SW-1:0]            f_d0_r, f_d1_r;
  logic signed [UNIT_W-1:0] g_u_r [4];
  logic signed [UNIT_W-1:0] g_dot_r, g_crs_r;
  logic signed [UNIT_W-1:0] g_dot_nxt, g_crs_nxt;
  logic [SW-1:0]            g_d0_r, g_d1_r;
  logic signed [UNIT_W-1:0] h_u_r [4];
  logic signed [UNIT_W-1:0] h_k_r, h_k_nxt;
  logic                     h_cos_r, h_cos_nxt;
  logic [SW-1:0]            h_d0_r, h_d1_r;

  always_comb begin
    logic signed [PROD_W:0] sdot;
    logic signed [PROD_W:0] scrs;
    logic [UNIT_W-1:0]      mdot;
    logic [UNIT_W-1:0]      mcrs;
    for (int j = 0; j < 4; j++) begin
      e_u_nxt[j] = u_side_out.sgn[j] ? -UNIT_W'(u_quo[j]) : UNIT_W'(u_quo[j]);
    end
    f_p_nxt[0] = e_u_r[0] * e_u_r[2];
    f_p_nxt[1] = e_u_r[1] * e_u_r[3];
    f_p_nxt[2] = e_u_r[0] * e_u_r[3];
    f_p_nxt[3] = e_u_r[1] * e_u_r[2];
    sdot       = (PROD_W+1)'(f_p_r[0]) + (PROD_W+1)'(f_p_r[1]);
    scrs       = (PROD_W+1)'(f_p_r[2]) - (PROD_W+1)'(f_p_r[3]);
    g_dot_nxt  = UNIT_W'(sdot >>> UNIT_FRAC);
    g_crs_nxt  = UNIT_W'(scrs >>> UNIT_FRAC);
    mdot       = g_dot_r[UNIT_W-1] ? UNIT_W'(-g_dot_r) : UNIT_W'(g_dot_r);
    mcrs       = g_crs_r[UNIT_W-1] ? UNIT_W'(-g_crs_r) : UNIT_W'(g_crs_r);
    h_cos_nxt  = (mdot < mcrs);
    h_k_nxt    = h_cos_nxt ? g_dot_r : g_crs_r;
  end

  // ---------------------------------------------------------------------
  // Stage I: k times each unit component.
  // Stage J: the four gradient terms, the error and the scale.
  // Stage K: scale times each magnitude.
  // ---------------------------------------------------------------------
  logic                     i_vld_r, j_vld_r, k_vld_r;
  logic signed [UNIT_W-1:0] i_u_r [4];
  logic signed [PROD_W-1:0] i_m_r [4];
  logic signed [PROD_W-1:0] i_m_nxt [4];
  logic signed [UNIT_W-1:0] i_k_r;
  logic                     i_cos_r;
  logic [SW-1:0]            i_d0_r, i_d1_r;
  logic signed [TERM_W-1:0] j_t_r [4];
  logic signed [TERM_W-1:0] j_t_nxt [4];
  logic signed [TERM_W-1:0] j_e_r, j_e_nxt;
  logic [SW-1:0]            j_scale_r, j_scale_nxt;
  logic [SW-1:0]            j_d0_r, j_d1_r;
  logic                     j_cos_r, j_degen_r, j_degen_nxt;
  logic [NW-1:0]            k_n_r [4];
  logic [NW-1:0]            k_n_nxt [4];
  logic [NW-1:0]            k_ne_r, k_ne_nxt;
  logic [3:0]               k_neg_r, k_neg_nxt;
  logic                     k_nege_r;
  logic [SW-1:0]            k_d0_r, k_d1_r;
  logic                     k_cos_r, k_degen_r;

  always_comb begin
    logic signed [UNIT_W-1:0] pr [4];
    logic signed [TERM_W-1:0] ang;
    logic [TERM_W-1:0]        mt;
    logic [TERM_W-1:0]        me;
    for (int j = 0; j < 4; j++) begin
      i_m_nxt[j] = h_k_r * h_u_r[j];
      pr[j]      = UNIT_W'(i_m_r[j] >>> UNIT_FRAC);
    end
    // Index order of the unit components: ux0, uy0, ux1, uy1.
    if (i_cos_r) begin
      j_t_nxt[0] = TERM_W'(i_u_r[2]) - TERM_W'(pr[0]);
      j_t_nxt[1] = TERM_W'(i_u_r[0]) - TERM_W'(pr[2]);
      j_t_nxt[2] = TERM_W'(i_u_r[3]) - TERM_W'(pr[1]);
      j_t_nxt[3] = TERM_W'(i_u_r[1]) - TERM_W'(pr[3]);
      ang        = $signed({cos_r[CFG_W-1], cos_r, 16'h0000});
    end else begin
      j_t_nxt[0] = TERM_W'(i_u_r[3]) - TERM_W'(pr[0]);
      j_t_nxt[1] = TERM_W'(i_u_r[1]) + TERM_W'(pr[2]);
      j_t_nxt[2] = TERM_W'(i_u_r[2]) + TERM_W'(pr[1]);
      j_t_nxt[3] = TERM_W'(i_u_r[0]) - TERM_W'(pr[3]);
      ang        = $signed({sin_r[CFG_W-1], sin_r, 16'h0000});
    end
    j_e_nxt     = TERM_W'(i_k_r) - ang;
    j_scale_nxt = (i_d0_r > i_d1_r) ? i_d0_r : i_d1_r;
    j_degen_nxt = (i_d0_r == '0) || (i_d1_r == '0);
    for (int j = 0; j < 4; j++) begin
      mt           = j_t_r[j][TERM_W-1] ? TERM_W'(-j_t_r[j]) : TERM_W'(j_t_r[j]);
      k_neg_nxt[j] = j_t_r[j][TERM_W-1];
      k_n_nxt[j]   = j_scale_r * mt;
    end
    me       = j_e_r[TERM_W-1] ? TERM_W'(-j_e_r) : TERM_W'(j_e_r);
    k_ne_nxt = j_scale_r * me;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
      k_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= u_vld;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
      k_vld_r <= j_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_u_r     <= e_u_nxt;
      e_d0_r    <= u_side_out.d0;
      e_d1_r    <= u_side_out.d1;
      f_u_r     <= e_u_r;
      f_p_r     <= f_p_nxt;
      f_d0_r    <= e_d0_r;
      f_d1_r    <= e_d1_r;
      g_u_r     <= f_u_r;
      g_dot_r   <= g_dot_nxt;
      g_crs_r   <= g_crs_nxt;
      g_d0_r    <= f_d0_r;
      g_d1_r    <= f_d1_r;
      h_u_r     <= g_u_r;
      h_k_r     <= h_k_nxt;
      h_cos_r   <= h_cos_nxt;
      h_d0_r    <= g_d0_r;
      h_d1_r    <= g_d1_r;
      i_u_r     <= h_u_r;
      i_m_r     <= i_m_nxt;
      i_k_r     <= h_k_r;
      i_cos_r   <= h_cos_r;
      i_d0_r    <= h_d0_r;
      i_d1_r    <= h_d1_r;
      j_t_r     <= j_t_nxt;
      j_e_r     <= j_e_nxt;
      j_scale_r <= j_scale_nxt;
      j_d0_r    <= i_d0_r;
      j_d1_r    <= i_d1_r;
      j_cos_r   <= i_cos_r;
      j_degen_r <= j_degen_nxt;
      k_n_r     <= k_n_nxt;
      k_ne_r    <= k_ne_nxt;
      k_neg_r   <= k_neg_nxt;
      k_nege_r  <= j_e_r[TERM_W-1];
      k_d0_r    <= j_d0_r;
      k_d1_r    <= j_d1_r;
      k_cos_r   <= j_cos_r;
      k_degen_r <= j_degen_r;
    end
  end

  // ---------------------------------------------------------------------
  // Gradient divider: floor((scale * |t|) / 2^14 / d). A quotient that would
  // not fit in 32 bits is flagged up front and saturated at the end. The
  // residual divides by 2^30, which is a plain shift, and is finished here.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic              use_cos;
    logic              degen;
    logic [3:0]        neg;
    logic [3:0]        ovf;
    logic [OUT_W-1:0]  residual;
  } q_side_t;

  logic [SW-1:0]    q_rem [4];
  logic [OUT_W-1:0] q_num [4];
  logic [SW-1:0]    q_den [4];
  q_side_t          q_side_in, q_side_out;
  logic             q_vld;
  logic [OUT_W-1:0] q_quo [4];

  always_comb begin
    logic [SW-1:0] hi;
    logic [63:0]   qe;
    logic [63:0]   lim;
    logic [63:0]   rv;
    for (int j = 0; j < 4; j++) begin
      hi               = {{EXTW{1'b0}}, k_n_r[j][NW-1 -: HW]};
      q_den[j]         = j[0] ? k_d1_r : k_d0_r;
      q_side_in.ovf[j] = (hi >= q_den[j]);
      q_rem[j]         = q_side_in.ovf[j] ? '0 : hi;
      q_num[j]         = k_n_r[j][GRAD_SHIFT +: OUT_W];
    end
    q_side_in.neg      = k_neg_r;
    q_side_in.use_cos  = k_cos_r;
    q_side_in.degen    = k_degen_r;
    qe                 = 64'(k_ne_r >> UNIT_FRAC);
    lim                = k_nege_r ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    rv                 = (qe > lim) ? lim : qe;
    q_side_in.residual = k_nege_r ? OUT_W'(-rv) : OUT_W'(rv);
  end

  acr_div #(
    .LANES (4),
    .DB    (SW),
    .QB    (OUT_W),
    .SBW   ($bits(q_side_t))
  ) u_grad_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (k_vld_r),
    .rem_i  (q_rem),
    .num_i  (q_num),
    .den_i  (q_den),
    .side_i (q_side_in),
    .vld_o  (q_vld),
    .quo_o  (q_quo),
    .side_o (q_side_out)
  );

  // ---------------------------------------------------------------------
  // Output stage: saturate, apply the signs of each equation, zero out a
  // degenerate pair. This register also parts the result side from the
  // pipeline, so a waiting result holds while the stages behind it freeze.
  // ---------------------------------------------------------------------
  function automatic logic [OUT_W-1:0] clamp_pos(input logic signed [OUT_W+1:0] v);
    logic signed [OUT_W+1:0] top;
    top = (OUT_W+2)'(33'sh0_7FFF_FFFF);
    return (v > top) ? OUT_W'(top) : OUT_W'(v);
  endfunction

  logic                           out_vld_r;
  logic [N_OUT*OUT_W-1:0]         out_data_r, out_data_nxt;
  logic [USER_W-1:0]              out_user_r, out_user_nxt;

  always_comb begin
    logic [OUT_W:0]          mq;
    logic [OUT_W:0]          lim;
    logic [OUT_W:0]          fm;
    logic signed [OUT_W+1:0] fs [4];
    logic [OUT_W-1:0]        pos [4];
    logic [OUT_W-1:0]        ngv [4];
    for (int j = 0; j < 4; j++) begin
      mq     = q_side_out.ovf[j] ? {1'b0, {OUT_W{1'b1}}} : {1'b0, q_quo[j]};
      lim    = q_side_out.neg[j] ? 33'h1_0000_0000 >> 1 : 33'h0_7FFF_FFFF;
      fm     = (mq > lim) ? lim : mq;
      fs[j]  = q_side_out.neg[j] ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
      pos[j] = clamp_pos(fs[j]);
      ngv[j] = clamp_pos(-fs[j]);
    end
    out_data_nxt[0*OUT_W +: OUT_W] = q_side_out.residual;
    out_data_nxt[1*OUT_W +: OUT_W] = ngv[0];
    out_data_nxt[2*OUT_W +: OUT_W] = pos[0];
    out_data_nxt[3*OUT_W +: OUT_W] = q_side_out.use_cos ? ngv[1] : pos[1];
    out_data_nxt[4*OUT_W +: OUT_W] = q_side_out.use_cos ? pos[1] : ngv[1];
    out_data_nxt[5*OUT_W +: OUT_W] = q_side_out.use_cos ? ngv[2] : pos[2];
    out_data_nxt[6*OUT_W +: OUT_W] = q_side_out.use_cos ? pos[2] : ngv[2];
    out_data_nxt[7*OUT_W +: OUT_W] = ngv[3];
    out_data_nxt[8*OUT_W +: OUT_W] = pos[3];
    out_user_nxt[USER_COS]         = q_side_out.use_cos;
    out_user_nxt[USER_DEGEN]       = q_side_out.degen;
    if (q_side_out.degen) begin
      out_data_nxt           = '0;
      out_user_nxt[USER_COS] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ design/acr_checker.sv @@
module acr_checker (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic                                     in_tready,
  input logic                                     out_tvalid,
  input logic                                     out_tready,
  input logic [acr_pkg::N_OUT*acr_pkg::OUT_W-1:0] out_tdata,
  input logic [acr_pkg::USER_W-1:0]               out_tuser
);
  import acr_pkg::*;

  // Reset empties the pipeline, so no result shows in the following cycle.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("waiting result changed");

  // With the output slot empty the pipeline must be free to take a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A degenerate pair reports nothing but the flag.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_DEGEN] |-> out_tdata == '0 && !out_tuser[USER_COS])
    else $error("degenerate result carries values");

endmodule

bind angle_constraint_residual_gradient acr_checker u_acr_checker (.*);
